@@ src/pbscan_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbscan_pkg
// Types and constants shared by the protobuf message type scanner modules.
// ----------------------------------------------------------------------------
package pbscan_pkg;

  // Field number width and reset values
  localparam int unsigned FieldW = 29;
  localparam logic [FieldW-1:0] TypeFieldRst  = 29'd10;
  localparam logic [FieldW-1:0] HelloFieldRst = 29'd40;

  // Configuration register indexes
  localparam logic [1:0] CfgTypeField  = 2'd0;
  localparam logic [1:0] CfgHelloField = 2'd1;

  // Protobuf wire types
  localparam logic [2:0] WkVarint = 3'd0;
  localparam logic [2:0] WkFixed64 = 3'd1;
  localparam logic [2:0] WkLenDelim = 3'd2;
  localparam logic [2:0] WkFixed32 = 3'd5;

  // Varint limit and fixed field lengths
  localparam logic [3:0] VarintLastIdx = 4'd9;
  localparam logic [63:0] Fixed64Len = 64'd8;
  localparam logic [63:0] Fixed32Len = 64'd4;

  // Scanner phases, one-hot
  typedef enum logic [5:0] {
    PH_TAG   = 6'b000001,
    PH_SKIPV = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_SKIPB = 6'b001000,
    PH_TYPE  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_TYPE   = 2'd0,
    ST_HELLO  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] msg_type;
  } out_item_t;

  // Scanner state carried between bytes
  typedef struct packed {
    phase_e      phase;
    logic [63:0] varint_accum;
    logic [3:0]  varint_shift;
    logic [63:0] skip_remaining;
    logic        hello_seen;
  } scan_state_t;

  localparam scan_state_t ScanStateRst = '{
    phase:          PH_TAG,
    varint_accum:   64'd0,
    varint_shift:   4'd0,
    skip_remaining: 64'd0,
    hello_seen:     1'b0
  };

  // Field number configuration
  typedef struct packed {
    logic [FieldW-1:0] type_field;
    logic [FieldW-1:0] hello_field;
  } scan_cfg_t;

endpackage

`default_nettype wire

@@ src/pbscan_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbscan_step
// Next-state and result logic for one payload byte of the scanner.
// ----------------------------------------------------------------------------
module pbscan_step import pbscan_pkg::*; (
  input  var scan_state_t cur_i,
  input  var in_item_t    item_i,
  input  var scan_cfg_t   cfg_i,
  output scan_state_t     nxt_o,
  output logic            res_valid_o,
  output out_item_t       res_o
);

  logic [3:0]  sh;
  logic [5:0]  shamt;
  logic [63:0] acc;
  logic [63:0] skip_dec;
  logic [60:0] fld;
  logic [2:0]  wk;
  logic        last;

  assign last     = item_i.end_of_payload;
  assign sh       = (cur_i.varint_shift > VarintLastIdx) ? VarintLastIdx : cur_i.varint_shift;
  assign shamt    = {2'b00, sh} * 6'd7;
  assign acc      = cur_i.varint_accum | ({57'd0, item_i.data_byte[6:0]} << shamt);
  assign skip_dec = (cur_i.skip_remaining != 64'd0) ? cur_i.skip_remaining - 64'd1
                                                    : cur_i.skip_remaining;
  assign fld      = acc[63:3];
  assign wk       = acc[2:0];

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_REJECT, msg_type: 64'd0};

    if (cur_i.phase == PH_DONE) begin
      // Drop bytes until the end of the payload
      if (last) begin
        nxt_o = ScanStateRst;
      end
    end else begin
      if (cur_i.phase == PH_SKIPB) begin
        // Count down the skipped field body
        nxt_o.skip_remaining = skip_dec;
        if (skip_dec == 64'd0) begin
          nxt_o.phase = PH_TAG;
        end
      end else begin
        // Collect one varint byte
        nxt_o.varint_accum = acc;
        if (item_i.data_byte[7]) begin
          if (sh >= VarintLastIdx) begin
            res_valid_o = 1'b1;
          end else begin
            nxt_o.varint_shift = sh + 4'd1;
          end
        end else begin
          nxt_o.varint_accum = 64'd0;
          nxt_o.varint_shift = 4'd0;
          unique case (cur_i.phase)
            PH_TAG: begin
              if (acc == 64'd0) begin
                res_valid_o = 1'b1;
              end else if (fld == {32'd0, cfg_i.type_field}) begin
                if (wk != WkVarint) begin
                  res_valid_o = 1'b1;
                end else begin
                  nxt_o.phase = PH_TYPE;
                end
              end else begin
                if (fld == {32'd0, cfg_i.hello_field} && wk == WkLenDelim) begin
                  nxt_o.hello_seen = 1'b1;
                end
                case (wk)
                  WkVarint:   nxt_o.phase = PH_SKIPV;
                  WkFixed64: begin
                    nxt_o.phase          = PH_SKIPB;
                    nxt_o.skip_remaining = Fixed64Len;
                  end
                  WkLenDelim: nxt_o.phase = PH_LEN;
                  WkFixed32: begin
                    nxt_o.phase          = PH_SKIPB;
                    nxt_o.skip_remaining = Fixed32Len;
                  end
                  default:    res_valid_o = 1'b1;
                endcase
              end
            end
            PH_SKIPV: nxt_o.phase = PH_TAG;
            PH_LEN: begin
              if (acc == 64'd0) begin
                nxt_o.phase = PH_TAG;
              end else begin
                nxt_o.skip_remaining = acc;
                nxt_o.phase          = PH_SKIPB;
              end
            end
            PH_TYPE: begin
              res_valid_o = 1'b1;
              res_o       = '{status: ST_TYPE, msg_type: acc};
            end
            default: nxt_o.phase = PH_TAG;
          endcase
        end
      end

      // Decide at the last byte if nothing decided yet
      if (!res_valid_o && last) begin
        res_valid_o = 1'b1;
        if (nxt_o.phase == PH_TAG && nxt_o.varint_shift == 4'd0 && nxt_o.hello_seen) begin
          res_o.status = ST_HELLO;
        end
      end

      // Close out the payload after a result
      if (res_valid_o) begin
        if (last) begin
          nxt_o = ScanStateRst;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/protobuf_message_type_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_message_type_scanner
// Scans a protobuf payload byte by byte and reports its type varint, a hello
// envelope, or a reject.
//
//   channel  direction  handshake        payload
//   in       input      valid / stall    in_item_t  (data_byte, end_of_payload)
//   out      output     valid / stall    out_item_t (status, msg_type)
//   cfg      input      valid / ready    index (2 bit), data (32 bit, low 29 bits field number)
//
// One byte is accepted per cycle while the input stage does not stall; a result
// passes through the input register, then the result register.
// Reset clears the scan state and sets the field numbers to 10 and 40.
// A stalled result holds the result register; the input stage stalls only
// while the result register is full and stalled.
// ----------------------------------------------------------------------------
module protobuf_message_type_scanner import pbscan_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      in_valid_i,
  output logic          in_stall_o,
  input  var in_item_t  in_data_i,
  output logic          out_valid_o,
  input  var logic      out_stall_i,
  output out_item_t     out_data_o,
  input  var logic      cfg_valid_i,
  output logic          cfg_ready_o,
  input  var logic [1:0]  cfg_index_i,
  input  var logic [31:0] cfg_data_i
);

  logic        in_valid_q;
  in_item_t    in_item_q;
  scan_state_t state_q, state_d;
  scan_cfg_t   cfg_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  logic        advance;
  logic        res_valid;
  out_item_t   res;

  assign cfg_ready_o = 1'b1;

  // Advance the input stage unless a result is stuck in the output register
  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Write field number registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{type_field: TypeFieldRst, hello_field: HelloFieldRst};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTypeField:  cfg_q.type_field  <= cfg_data_i[FieldW-1:0];
        CfgHelloField: cfg_q.hello_field <= cfg_data_i[FieldW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  pbscan_step u_step (
    .cur_i       (state_q),
    .item_i      (in_item_q),
    .cfg_i       (cfg_q),
    .nxt_o       (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Advance the scan state one byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ScanStateRst;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire

@@ dv/tb_protobuf_message_type_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_protobuf_message_type_scanner
// Self-checking bench for the protobuf message type scanner. A short table of
// hand-built payloads runs at the reset field numbers. Then phases of random
// payloads run under several field number settings and idle patterns. Most
// random payloads are well formed with random content. The rest are noise,
// truncated payloads, zero tags, bad wire types, wide tags and overlong
// varints. A local scan model predicts the random results, the table carries
// its own, and each result is compared in order against these expectations.
// ----------------------------------------------------------------------------
module tb_protobuf_message_type_scanner;
  import pbscan_pkg::*;

  localparam int ClkHalf      = 6;
  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 8;
  localparam int LongHold     = 150;
  localparam int QuietLimit   = 2000;
  localparam int PhaseBytes   = 200;
  localparam int unsigned MaxField = 2 ** FieldW - 1;
  localparam logic [1:0]  CfgSpare = 2'd3;
  localparam logic [63:0] AllOnes  = '1;

  // Typed expectation carried alongside a directed transaction
  typedef struct packed {
    logic      typed;
    out_item_t res;
  } fixed_expect_t;

  typedef struct {
    logic [7:0]  b;
    logic        last;
    logic        typed;
    status_e     st;
    logic [63:0] mt;
  } scan_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Scan model state and its copy of the field numbers
  phase_e            scan_phase;
  logic [63:0]       acc;
  logic [3:0]        nbytes;
  logic [63:0]       skip_left;
  logic              hello_flag;
  logic [FieldW-1:0] type_fld;
  logic [FieldW-1:0] hello_fld;

  out_item_t       pending_results[$];
  fixed_expect_t   fixed_expect_q[$];
  logic [7:0]      payload_bytes[$];
  int              mismatch_count = 0;
  int              quiet_cycles = 0;
  int              send_idle_pct = 0;
  bit              rx_stall_on = 1'b0;
  bit              hold_req = 1'b0;

  // Hand-built payloads at the reset field numbers (type 10, hello 40)
  scan_case_t scan_cases [24] = '{
    // zero tag
    '{8'h00, 1'b1, 1'b1, ST_REJECT, 64'd0},
    // unknown wire type
    '{8'h0B, 1'b1, 1'b1, ST_REJECT, 64'd0},
    // type field with the wrong wire type, then a dropped last byte
    '{8'h52, 1'b0, 1'b1, ST_REJECT, 64'd0},
    '{8'hFF, 1'b1, 1'b0, ST_TYPE, 64'd0},
    // plain type field
    '{8'h50, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'h01, 1'b1, 1'b1, ST_TYPE, 64'd1},
    // hello envelope with one content byte
    '{8'hC2, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'h02, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'h01, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hAA, 1'b1, 1'b1, ST_HELLO, 64'd0},
    // varint field cut off by the end of the payload
    '{8'h08, 1'b1, 1'b1, ST_REJECT, 64'd0},
    // payload ends with neither type nor hello
    '{8'h08, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'h05, 1'b1, 1'b1, ST_REJECT, 64'd0},
    // ten-byte type varint carrying all ones
    '{8'h50, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'hFF, 1'b0, 1'b0, ST_TYPE, 64'd0},
    '{8'h7F, 1'b1, 1'b1, ST_TYPE, AllOnes}
  };

  protobuf_message_type_scanner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Scan model
  // --------------------------------------------------------------------------
  function automatic void restart_payload();
    scan_phase = PH_TAG;
    acc        = '0;
    nbytes     = '0;
    skip_left  = '0;
    hello_flag = 1'b0;
  endfunction

  // Advance the model by one byte; return 1 when the byte decides the payload
  function automatic bit scan_byte(input in_item_t it, output out_item_t res);
    logic [63:0] v;
    logic [63:0] fld;
    logic [63:0] mt;
    logic [3:0]  sh;
    logic [2:0]  wkind;
    bit          decided;
    status_e     stat;
    decided = 1'b0;
    stat    = ST_REJECT;
    mt      = '0;
    res     = '0;
    if (scan_phase == PH_DONE) begin
      if (it.end_of_payload) restart_payload();
      return 1'b0;
    end
    if (scan_phase == PH_SKIPB) begin
      if (skip_left != 0) skip_left--;
      if (skip_left == 0) scan_phase = PH_TAG;
    end else begin
      sh = (nbytes > VarintLastIdx) ? VarintLastIdx : nbytes;
      acc |= 64'(it.data_byte[6:0]) << (7 * sh);
      if (it.data_byte[7]) begin
        // tenth byte still continuing: overlong varint
        if (sh >= VarintLastIdx) decided = 1'b1;
        else nbytes = sh + 4'd1;
      end else begin
        v      = acc;
        acc    = '0;
        nbytes = '0;
        case (scan_phase)
          PH_TAG: begin
            if (v == 0) begin
              decided = 1'b1;
            end else begin
              fld   = v >> 3;
              wkind = v[2:0];
              if (fld == 64'(type_fld)) begin
                if (wkind != WkVarint) decided = 1'b1;
                else scan_phase = PH_TYPE;
              end else begin
                if (fld == 64'(hello_fld) && wkind == WkLenDelim) hello_flag = 1'b1;
                case (wkind)
                  WkVarint: scan_phase = PH_SKIPV;
                  WkFixed64: begin
                    scan_phase = PH_SKIPB;
                    skip_left  = Fixed64Len;
                  end
                  WkLenDelim: scan_phase = PH_LEN;
                  WkFixed32: begin
                    scan_phase = PH_SKIPB;
                    skip_left  = Fixed32Len;
                  end
                  default: decided = 1'b1;
                endcase
              end
            end
          end
          PH_SKIPV: scan_phase = PH_TAG;
          PH_LEN: begin
            if (v == 0) begin
              scan_phase = PH_TAG;
            end else begin
              skip_left  = v;
              scan_phase = PH_SKIPB;
            end
          end
          default: begin
            decided = 1'b1;
            stat    = ST_TYPE;
            mt      = v;
          end
        endcase
      end
    end
    // end of payload: hello only from a clean tag boundary
    if (!decided && it.end_of_payload) begin
      decided = 1'b1;
      if (scan_phase == PH_TAG && nbytes == 0 && hello_flag) stat = ST_HELLO;
      else stat = ST_REJECT;
    end
    if (!decided) return 1'b0;
    res.status   = stat;
    res.msg_type = (stat == ST_TYPE) ? mt : '0;
    if (it.end_of_payload) restart_payload();
    else scan_phase = PH_DONE;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Payload generation
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // Append a varint, now and then padded with redundant continuation bytes
  function automatic void add_varint(input logic [63:0] v);
    int groups;
    int total;
    logic [7:0] b;
    groups = 1;
    while (groups < 10 && (v >> (7 * groups)) != 0) groups++;
    total = ($urandom_range(0, 19) == 0) ? $urandom_range(groups, 11) : groups;
    for (int i = 0; i < total; i++) begin
      b = {1'b0, 7'(v >> (7 * i))};
      if (i < total - 1) b[7] = 1'b1;
      payload_bytes.push_back(b);
    end
  endfunction

  task automatic build_payload();
    int          pick;
    int          nbody;
    logic [63:0] fnum;
    logic [63:0] tag;
    logic [63:0] len;
    logic [2:0]  wk;
    payload_bytes.delete();
    if ($urandom_range(0, 99) < 8) begin
      // noise
      repeat ($urandom_range(1, 6)) payload_bytes.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) fnum = 64'(type_fld);
      else if (pick < 40) fnum = 64'(hello_fld);
      else if (pick < 85) fnum = 64'($urandom_range(1, 15));
      else if (pick < 95) fnum = 64'($urandom_range(1, MaxField));
      else fnum = rand_wide() | (64'd1 << 33);
      pick = $urandom_range(0, 99);
      if (pick < 30) wk = WkVarint;
      else if (pick < 45) wk = WkFixed64;
      else if (pick < 75) wk = WkLenDelim;
      else if (pick < 92) wk = WkFixed32;
      else begin
        do wk = 3'($urandom);
        while (wk inside {WkVarint, WkFixed64, WkLenDelim, WkFixed32});
      end
      // favor the proper wire type on the special fields
      if ($urandom_range(0, 9) < 7) begin
        if (fnum == 64'(type_fld)) wk = WkVarint;
        else if (fnum == 64'(hello_fld)) wk = WkLenDelim;
      end
      tag = (fnum << 3) | 64'(wk);
      if ($urandom_range(0, 32) == 0) tag = '0;
      add_varint(tag);
      case (wk)
        WkVarint: add_varint(rand_wide());
        WkFixed64: repeat (8) payload_bytes.push_back(8'($urandom));
        WkFixed32: repeat (4) payload_bytes.push_back(8'($urandom));
        WkLenDelim: begin
          len = ($urandom_range(0, 19) == 0) ? rand_wide() : 64'($urandom_range(0, 5));
          nbody = (len > 5) ? 5 : int'(len);
          add_varint(len);
          repeat (nbody) payload_bytes.push_back(8'($urandom));
        end
        default: ;
      endcase
    end
    // truncate some payloads
    if ($urandom_range(0, 9) == 0 && payload_bytes.size() > 1) begin
      repeat ($urandom_range(1, payload_bytes.size() - 1)) void'(payload_bytes.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_byte(input in_item_t it, input fixed_expect_t fx);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    fixed_expect_q.push_back(fx);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the input, wait for every result, then let the pipeline settle
  task automatic drain_scanner();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic run_phase(input bit spare, input logic [31:0] type_v,
                           input logic [31:0] hello_v, input int idle_pct,
                           input bit rx_stall, input bit squeeze);
    int sent;
    in_item_t it;
    drain_scanner();
    if (spare) write_reg(CfgSpare, $urandom);
    write_reg(CfgTypeField, type_v);
    write_reg(CfgHelloField, hello_v);
    cfg_valid_i   <= 1'b0;
    send_idle_pct = idle_pct;
    rx_stall_on   = rx_stall;
    if (squeeze) hold_req = 1'b1;
    sent = 0;
    while (sent < PhaseBytes) begin
      build_payload();
      foreach (payload_bytes[i]) begin
        it.data_byte      = payload_bytes[i];
        it.end_of_payload = (i == payload_bytes.size() - 1);
        send_byte(it, '0);
      end
      sent += payload_bytes.size();
    end
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (pick_gap()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and checks
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : observe
    out_item_t     predicted;
    out_item_t     want;
    fixed_expect_t fx;
    bit            has_res;
    bit            progress;
    progress = 1'b0;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      // track field number writes
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        case (cfg_index_i)
          CfgTypeField:  type_fld = cfg_data_i[FieldW-1:0];
          CfgHelloField: hello_fld = cfg_data_i[FieldW-1:0];
          default: ;
        endcase
      end
      // predict on each accepted byte
      if (in_valid_i && !in_stall_o) begin
        progress = 1'b1;
        fx = fixed_expect_q.pop_front();
        has_res = scan_byte(in_data_i, predicted);
        if (fx.typed) pending_results.push_back(fx.res);
        else if (has_res) pending_results.push_back(predicted);
      end
      // compare each accepted result with the oldest expectation
      if (out_valid_o && !out_stall_i) begin
        progress = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d type=%h",
                                    out_data_o.status, out_data_o.msg_type));
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data_o.status, want.status));
          if (out_data_o.msg_type !== want.msg_type)
            report_mismatch($sformatf("msg_type %h, expected %h",
                                      out_data_o.msg_type, want.msg_type));
        end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    in_item_t      it;
    fixed_expect_t fx;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgTypeField;
    cfg_data_i  = '0;
    type_fld    = TypeFieldRst;
    hello_fld   = HelloFieldRst;
    restart_payload();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed payloads at the reset field numbers
    send_idle_pct = 30;
    rx_stall_on   = 1'b1;
    foreach (scan_cases[i]) begin
      it.data_byte      = scan_cases[i].b;
      it.end_of_payload = scan_cases[i].last;
      fx.typed          = scan_cases[i].typed;
      fx.res.status     = scan_cases[i].st;
      fx.res.msg_type   = scan_cases[i].mt;
      send_byte(it, fx);
    end

    // random payloads under several field number settings
    run_phase(1'b0, 32'd1, MaxField, 0, 1'b0, 1'b0);
    run_phase(1'b0, MaxField, 32'd1, 30, 1'b0, 1'b0);
    run_phase(1'b1, 32'hE000_0007, 32'd7, 0, 1'b1, 1'b1);
    run_phase(1'b0, $urandom_range(1, MaxField), $urandom_range(1, 20), 30, 1'b1, 1'b0);
    run_phase(1'b0, 32'(TypeFieldRst), 32'(HelloFieldRst), 20, 1'b1, 1'b0);
    drain_scanner();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
